[src/tfdg_pkg.sv]
// ============================================================================
// tfdg_pkg
// Shared widths, frame constants, reset values and types for the target
// frame decoder and gate.
// ============================================================================
package tfdg_pkg;

    localparam int BYTE_W   = 8;
    localparam int TIME_W   = 32;
    localparam int ANGLE_W  = 16;
    localparam int DIST_W   = 8;
    localparam int FLAG_W   = 8;
    localparam int WIN_W    = 16;

    localparam logic [BYTE_W-1:0] HDR_BYTE  = 8'hFF;
    localparam logic [BYTE_W-1:0] TAIL_BYTE = 8'hFE;
    localparam int                BODY_LEN  = 6;
    localparam int                IDX_W     = $clog2(BODY_LEN);

    localparam int ANGLE_TAPS_DEF = 3;
    localparam int DIST_TAPS_DEF  = 9;

    localparam logic [TIME_W-1:0] LOST_TIMEOUT_RST    = 32'd500000;
    localparam logic [TIME_W-1:0] REACQ_TIMEOUT_RST   = 32'd100000;
    localparam logic [WIN_W-1:0]  JUMP_LIMIT_RST      = 16'd4000;
    localparam logic [WIN_W-1:0]  TRACK_WINDOW_RST    = 16'd800;

    localparam logic [FLAG_W-1:0] FLAG_NONE  = 8'd0;
    localparam logic [FLAG_W-1:0] FLAG_TRACK = 8'd1;

    // Decoded frame body
    typedef struct packed {
        logic [FLAG_W-1:0]         flag;
        logic signed [ANGLE_W-1:0] yaw;
        logic signed [ANGLE_W-1:0] pitch;
        logic [DIST_W-1:0]         dist_cm;
    } t_frame;

    // Parser status toward the gate
    typedef struct packed {
        logic   frame_done;
        t_frame frame;
    } t_parse;

endpackage

[src/tfdg_if.sv]
// ============================================================================
// tfdg_if
// Valid/ready stream channels for received bytes and gated target results.
// ============================================================================
interface tfdg_in_if;
    logic                         valid;
    logic                         ready;
    logic [tfdg_pkg::BYTE_W-1:0]  rx_byte;
    logic [tfdg_pkg::TIME_W-1:0]  time_us;

    modport source (output valid, output rx_byte, output time_us, input ready);
    modport sink   (input valid, input rx_byte, input time_us, output ready);
endinterface

interface tfdg_out_if;
    logic                                valid;
    logic                                ready;
    logic [tfdg_pkg::FLAG_W-1:0]         target_flag;
    logic signed [tfdg_pkg::ANGLE_W-1:0] yaw_cdeg;
    logic signed [tfdg_pkg::ANGLE_W-1:0] pitch_cdeg;
    logic [tfdg_pkg::DIST_W-1:0]         distance_cm;
    logic                                accepted;

    modport source (output valid, output target_flag, output yaw_cdeg, output pitch_cdeg,
                    output distance_cm, output accepted, input ready);
    modport sink   (input valid, input target_flag, input yaw_cdeg, input pitch_cdeg,
                    input distance_cm, input accepted, output ready);
endinterface

[src/tfdg_const_div.sv]
// ============================================================================
// tfdg_const_div
// Unsigned divide by a constant through one reciprocal multiply, exact for
// every dividend of WIDTH bits.
// ============================================================================
module tfdg_const_div #(
    parameter int WIDTH   = 18,
    parameter int DIVISOR = 3
) (
    input  logic [WIDTH-1:0] i_num,
    output logic [WIDTH-1:0] o_quot
);

    // Shift of WIDTH plus log2 of the divisor keeps the rounded-up
    // reciprocal error below one unit of the quotient.
    localparam int              SHIFT  = WIDTH + $clog2(DIVISOR);
    localparam longint unsigned MULT_L =
        ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [WIDTH:0]  MULT   = MULT_L[WIDTH:0];
    localparam int              PROD_W = SHIFT + WIDTH + 1;

    logic [PROD_W-1:0] w_prod;

    assign w_prod = PROD_W'(i_num) * PROD_W'(MULT);
    assign o_quot = w_prod[SHIFT +: WIDTH];

endmodule

[src/tfdg_frame_parse.sv]
// ============================================================================
// tfdg_frame_parse
// Header/body/tail framer: collects six body bytes after a header and flags
// a complete frame when the tail byte matches.
// ============================================================================
module tfdg_frame_parse (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [tfdg_pkg::BYTE_W-1:0] i_byte,
    output tfdg_pkg::t_parse            o_parse
);

    typedef enum logic [2:0] {
        PH_WAIT = 3'b001,
        PH_BODY = 3'b010,
        PH_TAIL = 3'b100
    } t_phase;

    t_phase                          r_phase, n_phase;
    logic [tfdg_pkg::IDX_W-1:0]      r_idx, n_idx;
    logic [tfdg_pkg::BYTE_W-1:0]     r_body [tfdg_pkg::BODY_LEN];

    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        unique case (r_phase)
            PH_WAIT: begin
                n_idx = '0;
                if (i_byte == tfdg_pkg::HDR_BYTE) begin
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                if (r_idx == tfdg_pkg::IDX_W'(tfdg_pkg::BODY_LEN - 1)) begin
                    n_idx   = '0;
                    n_phase = PH_TAIL;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            PH_TAIL: begin
                n_idx   = '0;
                n_phase = PH_WAIT;
            end
            default: begin
                n_idx   = '0;
                n_phase = PH_WAIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT;
            r_idx   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
        end
    end

    // Body bytes: written by position, never read before being written
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < tfdg_pkg::BODY_LEN; k++) begin
            if (i_step && r_phase == PH_BODY && r_idx == tfdg_pkg::IDX_W'(k)) begin
                r_body[k] <= i_byte;
            end
        end
    end

    assign o_parse.frame_done    = (r_phase == PH_TAIL) && (i_byte == tfdg_pkg::TAIL_BYTE);
    assign o_parse.frame.flag    = r_body[0];
    assign o_parse.frame.yaw     = {r_body[2], r_body[1]};
    assign o_parse.frame.pitch   = {r_body[4], r_body[3]};
    assign o_parse.frame.dist_cm = r_body[5];

endmodule

[src/target_frame_decode_gate.sv]
// ============================================================================
// target_frame_decode_gate
// Frame decoder, target gate and moving-average smoother for a serial
// target-report stream.
// ============================================================================
//
// Usage:
//   i_in_ch carries one received byte per transfer with its microsecond
//   time stamp. Frames are FF, flag, yaw lo/hi, pitch lo/hi, distance, FE.
//   o_out_ch carries one result per frame with a good tail: the gated flag,
//   smoothed yaw/pitch, distance and whether this frame updated the track.
//   Bytes outside frames and frames with a bad tail give no result.
//   The APB port holds four registers at byte offsets 0, 4, 8, 12: lost
//   timeout, reacquire timeout, jump limit, tracking window. Write them only
//   while no byte is in flight.
// Timing:
//   One byte per cycle is accepted, except that a tail byte waits in the
//   input register until the result slot is free. There the whole gate and
//   average update is done; the result register loads as the tail byte
//   leaves the input register and then offers the result. The update is a
//   single per-frame pass (sum, reciprocal multiply, compare).
// Reset and stall:
//   Reset clears the parser, histories, held values and registers to their
//   defaults at once; no clearing pass. While the receiver stalls, the
//   result is held and bytes keep flowing until the next tail byte, which
//   waits in the input register.
// ============================================================================
module target_frame_decode_gate #(
    parameter int ANGLE_TAPS = tfdg_pkg::ANGLE_TAPS_DEF,
    parameter int DIST_TAPS  = tfdg_pkg::DIST_TAPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tfdg_in_if.sink            i_in_ch,
    tfdg_out_if.source         o_out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int ANGLE_SUM_W = tfdg_pkg::ANGLE_W + $clog2(ANGLE_TAPS);
    localparam int DIST_SUM_W  = tfdg_pkg::DIST_W + $clog2(DIST_TAPS);

    localparam logic [1:0] REG_LOST  = 2'd0;
    localparam logic [1:0] REG_REACQ = 2'd1;
    localparam logic [1:0] REG_JUMP  = 2'd2;
    localparam logic [1:0] REG_WIN   = 2'd3;

    // ---------------------------------------------------------------- config
    logic [tfdg_pkg::TIME_W-1:0] r_lost_to;
    logic [tfdg_pkg::TIME_W-1:0] r_reacq_to;
    logic [tfdg_pkg::WIN_W-1:0]  r_jump_lim;
    logic [tfdg_pkg::WIN_W-1:0]  r_track_win;
    logic                        w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lost_to   <= tfdg_pkg::LOST_TIMEOUT_RST;
            r_reacq_to  <= tfdg_pkg::REACQ_TIMEOUT_RST;
            r_jump_lim  <= tfdg_pkg::JUMP_LIMIT_RST;
            r_track_win <= tfdg_pkg::TRACK_WINDOW_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_LOST:  r_lost_to   <= pwdata;
                REG_REACQ: r_reacq_to  <= pwdata;
                REG_JUMP:  r_jump_lim  <= pwdata[tfdg_pkg::WIN_W-1:0];
                REG_WIN:   r_track_win <= pwdata[tfdg_pkg::WIN_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_LOST:  prdata = r_lost_to;
            REG_REACQ: prdata = r_reacq_to;
            REG_JUMP:  prdata = 32'(r_jump_lim);
            REG_WIN:   prdata = 32'(r_track_win);
            default:   prdata = '0;
        endcase
    end

    // --------------------------------------------------------- input register
    logic                        r_s1_valid;
    logic [tfdg_pkg::BYTE_W-1:0] r_s1_byte;
    logic [tfdg_pkg::TIME_W-1:0] r_s1_time;
    logic                        r_out_valid;
    logic                        r_out_acc;
    logic                        w_out_free;
    logic                        w_s1_adv;
    logic                        w_emit;
    tfdg_pkg::t_parse            w_parse;

    assign w_out_free      = !r_out_valid || o_out_ch.ready;
    // A tail byte needs a free result slot; any other byte moves on freely.
    assign w_s1_adv        = r_s1_valid && (!w_parse.frame_done || w_out_free);
    assign w_emit          = w_s1_adv && w_parse.frame_done;
    assign i_in_ch.ready   = !r_s1_valid || w_s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in_ch.ready) begin
            r_s1_valid <= i_in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_ch.valid && i_in_ch.ready) begin
            r_s1_byte <= i_in_ch.rx_byte;
            r_s1_time <= i_in_ch.time_us;
        end
    end

    tfdg_frame_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_s1_adv),
        .i_byte  (r_s1_byte),
        .o_parse (w_parse)
    );

    // ------------------------------------------------------------ gate state
    logic signed [tfdg_pkg::ANGLE_W-1:0] r_yaw_hist   [ANGLE_TAPS];
    logic signed [tfdg_pkg::ANGLE_W-1:0] r_pitch_hist [ANGLE_TAPS];
    logic [tfdg_pkg::DIST_W-1:0]         r_dist_hist  [DIST_TAPS];
    logic signed [tfdg_pkg::ANGLE_W-1:0] n_yaw_hist   [ANGLE_TAPS];
    logic signed [tfdg_pkg::ANGLE_W-1:0] n_pitch_hist [ANGLE_TAPS];
    logic [tfdg_pkg::DIST_W-1:0]         n_dist_hist  [DIST_TAPS];
    logic signed [tfdg_pkg::ANGLE_W-1:0] r_yaw_held;
    logic signed [tfdg_pkg::ANGLE_W-1:0] r_pitch_held;
    logic [tfdg_pkg::DIST_W-1:0]         r_dist_held;
    logic [tfdg_pkg::FLAG_W-1:0]         r_flag_held;
    logic [tfdg_pkg::TIME_W-1:0]         r_last_acc;

    // Shift the new sample in at the top of each history
    always_comb begin
        for (int k = 0; k < ANGLE_TAPS - 1; k++) begin
            n_yaw_hist[k]   = r_yaw_hist[k+1];
            n_pitch_hist[k] = r_pitch_hist[k+1];
        end
        n_yaw_hist[ANGLE_TAPS-1]   = w_parse.frame.yaw;
        n_pitch_hist[ANGLE_TAPS-1] = w_parse.frame.pitch;
        for (int k = 0; k < DIST_TAPS - 1; k++) begin
            n_dist_hist[k] = r_dist_hist[k+1];
        end
        n_dist_hist[DIST_TAPS-1] = w_parse.frame.dist_cm;
    end

    // Window sums of the shifted histories
    logic signed [ANGLE_SUM_W-1:0] w_yaw_sum;
    logic signed [ANGLE_SUM_W-1:0] w_pitch_sum;
    logic [DIST_SUM_W-1:0]         w_dist_sum;

    always_comb begin
        w_yaw_sum   = '0;
        w_pitch_sum = '0;
        w_dist_sum  = '0;
        for (int k = 0; k < ANGLE_TAPS; k++) begin
            w_yaw_sum   = w_yaw_sum + ANGLE_SUM_W'(n_yaw_hist[k]);
            w_pitch_sum = w_pitch_sum + ANGLE_SUM_W'(n_pitch_hist[k]);
        end
        for (int k = 0; k < DIST_TAPS; k++) begin
            w_dist_sum = w_dist_sum + DIST_SUM_W'(n_dist_hist[k]);
        end
    end

    // Angle averages truncate toward zero: divide the magnitude, restore sign
    logic [ANGLE_SUM_W-1:0]              w_yaw_mag, w_pitch_mag;
    logic [ANGLE_SUM_W-1:0]              w_yaw_quot, w_pitch_quot;
    logic [DIST_SUM_W-1:0]               w_dist_quot;
    logic signed [tfdg_pkg::ANGLE_W-1:0] w_yaw_avg, w_pitch_avg;

    assign w_yaw_mag   = w_yaw_sum[ANGLE_SUM_W-1] ? (~w_yaw_sum + 1'b1) : w_yaw_sum;
    assign w_pitch_mag = w_pitch_sum[ANGLE_SUM_W-1] ? (~w_pitch_sum + 1'b1) : w_pitch_sum;

    tfdg_const_div #(.WIDTH(ANGLE_SUM_W), .DIVISOR(ANGLE_TAPS)) u_yaw_div (
        .i_num  (w_yaw_mag),
        .o_quot (w_yaw_quot)
    );

    tfdg_const_div #(.WIDTH(ANGLE_SUM_W), .DIVISOR(ANGLE_TAPS)) u_pitch_div (
        .i_num  (w_pitch_mag),
        .o_quot (w_pitch_quot)
    );

    tfdg_const_div #(.WIDTH(DIST_SUM_W), .DIVISOR(DIST_TAPS)) u_dist_div (
        .i_num  (w_dist_sum),
        .o_quot (w_dist_quot)
    );

    assign w_yaw_avg   = w_yaw_sum[ANGLE_SUM_W-1] ? -w_yaw_quot[tfdg_pkg::ANGLE_W-1:0]
                                                  : w_yaw_quot[tfdg_pkg::ANGLE_W-1:0];
    assign w_pitch_avg = w_pitch_sum[ANGLE_SUM_W-1] ? -w_pitch_quot[tfdg_pkg::ANGLE_W-1:0]
                                                    : w_pitch_quot[tfdg_pkg::ANGLE_W-1:0];

    // --------------------------------------------------------------- gating
    logic [tfdg_pkg::TIME_W-1:0]           w_elapsed;
    logic signed [tfdg_pkg::ANGLE_W:0]     w_jump_diff;
    logic [tfdg_pkg::ANGLE_W:0]            w_jump_mag;
    logic                                  w_jump_ok;
    logic                                  w_in_window;
    logic                                  w_accept;
    logic                                  w_flag_upd;
    logic                                  w_track_flag;

    assign w_elapsed   = r_s1_time - r_last_acc;
    assign w_jump_diff = (tfdg_pkg::ANGLE_W+1)'(r_yaw_held)
                       - (tfdg_pkg::ANGLE_W+1)'(w_parse.frame.yaw);
    assign w_jump_mag  = w_jump_diff[tfdg_pkg::ANGLE_W] ? (~w_jump_diff + 1'b1) : w_jump_diff;
    assign w_jump_ok   = (w_parse.frame.flag != tfdg_pkg::FLAG_NONE)
                       && (w_jump_mag < {1'b0, r_jump_lim});
    assign w_track_flag = (w_parse.frame.flag == tfdg_pkg::FLAG_TRACK);

    // Held yaw/pitch always equal the average of their own history (both
    // are zero at reset and both change only on acceptance), so their
    // distance from that average is zero: the window holds unless it is 0.
    assign w_in_window = (r_track_win != '0);

    assign w_accept   = w_jump_ok && (!w_track_flag || w_in_window || (w_elapsed > r_reacq_to));
    assign w_flag_upd = w_jump_ok || (w_elapsed > r_lost_to);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ANGLE_TAPS; k++) begin
                r_yaw_hist[k]   <= '0;
                r_pitch_hist[k] <= '0;
            end
            for (int k = 0; k < DIST_TAPS; k++) begin
                r_dist_hist[k] <= '0;
            end
            r_yaw_held   <= '0;
            r_pitch_held <= '0;
            r_dist_held  <= '0;
            r_flag_held  <= '0;
            r_last_acc   <= '0;
        end else if (w_emit) begin
            if (w_flag_upd) begin
                r_flag_held <= w_parse.frame.flag;
            end
            if (w_accept) begin
                r_yaw_hist   <= n_yaw_hist;
                r_pitch_hist <= n_pitch_hist;
                r_dist_hist  <= n_dist_hist;
                r_yaw_held   <= w_yaw_avg;
                r_pitch_held <= w_pitch_avg;
                r_dist_held  <= w_track_flag ? w_parse.frame.dist_cm
                                             : w_dist_quot[tfdg_pkg::DIST_W-1:0];
                r_last_acc   <= r_s1_time;
            end
        end
    end

    // -------------------------------------------------------- result register
    // Held values only change on a result transfer into a free slot, so they
    // double as the result payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_acc <= w_accept;
        end
    end

    assign o_out_ch.valid       = r_out_valid;
    assign o_out_ch.target_flag = r_flag_held;
    assign o_out_ch.yaw_cdeg    = r_yaw_held;
    assign o_out_ch.pitch_cdeg  = r_pitch_held;
    assign o_out_ch.distance_cm = r_dist_held;
    assign o_out_ch.accepted    = r_out_acc;

endmodule

[src/tfdg_checker.sv]
// ============================================================================
// tfdg_checker
// Port-level assertions for the target frame decoder, bound to the top.
// ============================================================================
module tfdg_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic [tfdg_pkg::FLAG_W-1:0]        i_out_flag,
    input logic signed [tfdg_pkg::ANGLE_W-1:0] i_out_yaw,
    input logic                               i_out_acc
);

    // No result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // An accepted frame always carries a nonzero target flag
    a_acc_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_acc |-> i_out_flag != tfdg_pkg::FLAG_NONE)
        else $error("accepted result with zero flag");

    // A stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // A stalled result holds its payload
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_flag) && $stable(i_out_yaw) && $stable(i_out_acc))
        else $error("result changed while stalled");

endmodule

bind target_frame_decode_gate tfdg_checker u_tfdg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_ch.valid),
    .i_out_ready (o_out_ch.ready),
    .i_out_flag  (o_out_ch.target_flag),
    .i_out_yaw   (o_out_ch.yaw_cdeg),
    .i_out_acc   (o_out_ch.accepted)
);

[tb/tfdg_tb_pkg.sv]
// ============================================================================
// tfdg_tb_pkg
// Register map of the target frame gate, as seen by the bench: the index of
// each configuration register on the APB port.
// ============================================================================
package tfdg_tb_pkg;

    typedef enum logic [1:0] {
        REG_LOST_TIMEOUT  = 2'd0,
        REG_REACQ_TIMEOUT = 2'd1,
        REG_JUMP_LIMIT    = 2'd2,
        REG_TRACK_WINDOW  = 2'd3
    } reg_idx_e;

endpackage

[tb/tfdg_gate_checker.sv]
// ============================================================================
// tfdg_gate_checker
// Passive frame decoder and target gate that mirrors the block from its
// byte stream and register writes, and compares every result transfer.
// ============================================================================
module tfdg_gate_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tfdg_in_if          i_in_mon,
    tfdg_out_if         i_out_mon,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output int          o_fail_count,
    output int          o_pending,
    output logic [31:0] o_last_accept_us
);
    import tfdg_pkg::*;
    import tfdg_tb_pkg::*;

    typedef enum logic [1:0] {SEEK_HDR, TAKE_BODY, TAKE_TAIL} parse_e;

    typedef struct packed {
        logic [FLAG_W-1:0]         flag;
        logic signed [ANGLE_W-1:0] yaw;
        logic signed [ANGLE_W-1:0] pitch;
        logic [DIST_W-1:0]         dist_cm;
        logic                      accepted;
    } report_t;

    // register shadows
    logic [TIME_W-1:0] lost_to;
    logic [TIME_W-1:0] reacq_to;
    logic [WIN_W-1:0]  jump_lim;
    logic [WIN_W-1:0]  win_lim;

    // mirrored block state
    parse_e                    phase;
    int                        body_idx;
    logic [BYTE_W-1:0]         body [BODY_LEN];
    logic signed [ANGLE_W-1:0] yaw_hist [ANGLE_TAPS_DEF];
    logic signed [ANGLE_W-1:0] pitch_hist [ANGLE_TAPS_DEF];
    logic [DIST_W-1:0]         dist_hist [DIST_TAPS_DEF];
    logic signed [ANGLE_W-1:0] yaw_held;
    logic signed [ANGLE_W-1:0] pitch_held;
    logic [DIST_W-1:0]         dist_held;
    logic [FLAG_W-1:0]         flag_held;
    logic [TIME_W-1:0]         last_acc_us;

    report_t report_q [$];
    int      fail_total = 0;

    task automatic clear_state();
        lost_to     = LOST_TIMEOUT_RST;
        reacq_to    = REACQ_TIMEOUT_RST;
        jump_lim    = JUMP_LIMIT_RST;
        win_lim     = TRACK_WINDOW_RST;
        phase       = SEEK_HDR;
        body_idx    = 0;
        for (int k = 0; k < BODY_LEN; k++) body[k] = '0;
        for (int k = 0; k < ANGLE_TAPS_DEF; k++) begin
            yaw_hist[k]   = '0;
            pitch_hist[k] = '0;
        end
        for (int k = 0; k < DIST_TAPS_DEF; k++) dist_hist[k] = '0;
        yaw_held    = '0;
        pitch_held  = '0;
        dist_held   = '0;
        flag_held   = '0;
        last_acc_us = '0;
        report_q.delete();
    endtask

    task automatic write_shadow(input logic [3:0] addr, input logic [31:0] data);
        case (reg_idx_e'(addr[3:2]))
            REG_LOST_TIMEOUT:  lost_to  = data;
            REG_REACQ_TIMEOUT: reacq_to = data;
            REG_JUMP_LIMIT:    jump_lim = data[WIN_W-1:0];
            REG_TRACK_WINDOW:  win_lim  = data[WIN_W-1:0];
            default: ;
        endcase
    endtask

    function automatic int mag(input int v);
        return (v < 0) ? -v : v;
    endfunction

    // truncating average of the yaw (0) or pitch (1) history
    function automatic int angle_mean(input bit pick_pitch);
        int s;
        s = 0;
        for (int k = 0; k < ANGLE_TAPS_DEF; k++)
            s += pick_pitch ? int'(pitch_hist[k]) : int'(yaw_hist[k]);
        return s / ANGLE_TAPS_DEF;
    endfunction

    function automatic int dist_mean();
        int s;
        s = 0;
        for (int k = 0; k < DIST_TAPS_DEF; k++) s += int'(dist_hist[k]);
        return s / DIST_TAPS_DEF;
    endfunction

    task automatic shift_in(input logic signed [ANGLE_W-1:0] y,
                            input logic signed [ANGLE_W-1:0] p,
                            input logic [DIST_W-1:0] d);
        for (int k = 1; k < ANGLE_TAPS_DEF; k++) begin
            yaw_hist[k-1]   = yaw_hist[k];
            pitch_hist[k-1] = pitch_hist[k];
        end
        yaw_hist[ANGLE_TAPS_DEF-1]   = y;
        pitch_hist[ANGLE_TAPS_DEF-1] = p;
        for (int k = 1; k < DIST_TAPS_DEF; k++) dist_hist[k-1] = dist_hist[k];
        dist_hist[DIST_TAPS_DEF-1] = d;
        yaw_held   = ANGLE_W'(angle_mean(1'b0));
        pitch_held = ANGLE_W'(angle_mean(1'b1));
    endtask

    task automatic gate_frame(input logic [TIME_W-1:0] t);
        logic [FLAG_W-1:0]         flag;
        logic signed [ANGLE_W-1:0] y;
        logic signed [ANGLE_W-1:0] p;
        logic [DIST_W-1:0]         d;
        logic [TIME_W-1:0]         since;
        logic                      win;
        logic                      took;
        flag  = body[0];
        y     = {body[2], body[1]};
        p     = {body[4], body[3]};
        d     = body[5];
        since = t - last_acc_us;
        took  = 1'b0;
        if (flag != FLAG_NONE && mag(int'(yaw_held) - int'(y)) < int'(jump_lim)) begin
            flag_held = flag;
            if (flag == FLAG_TRACK) begin
                win = mag(int'(yaw_held) - angle_mean(1'b0)) < int'(win_lim)
                   && mag(int'(pitch_held) - angle_mean(1'b1)) < int'(win_lim);
                if (win || since > reacq_to) begin
                    shift_in(y, p, d);
                    dist_held = d;
                    took      = 1'b1;
                end
            end else begin
                shift_in(y, p, d);
                dist_held = DIST_W'(dist_mean());
                took      = 1'b1;
            end
            if (took) last_acc_us = t;
        end else if (since > lost_to) begin
            flag_held = flag;
        end
        report_q.push_back({flag_held, yaw_held, pitch_held, dist_held, took});
    endtask

    task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic [TIME_W-1:0] t);
        case (phase)
            TAKE_BODY: begin
                body[body_idx] = b;
                body_idx++;
                if (body_idx == BODY_LEN) begin
                    body_idx = 0;
                    phase    = TAKE_TAIL;
                end
            end
            TAKE_TAIL: begin
                phase    = SEEK_HDR;
                body_idx = 0;
                if (b == TAIL_BYTE) gate_frame(t);
            end
            default: begin
                if (b == HDR_BYTE) begin
                    phase    = TAKE_BODY;
                    body_idx = 0;
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_total++;
        end
    endtask

    task automatic check_report();
        report_t want;
        if (report_q.size() == 0) begin
            $error("result with no frame behind it: flag %0d yaw %0d pitch %0d distance %0d",
                   i_out_mon.target_flag, i_out_mon.yaw_cdeg, i_out_mon.pitch_cdeg,
                   i_out_mon.distance_cm);
            fail_total++;
        end else begin
            want = report_q.pop_front();
            check_field("target_flag", want.flag, i_out_mon.target_flag);
            check_field("yaw_cdeg", want.yaw, i_out_mon.yaw_cdeg);
            check_field("pitch_cdeg", want.pitch, i_out_mon.pitch_cdeg);
            check_field("distance_cm", want.dist_cm, i_out_mon.distance_cm);
            check_field("accepted", want.accepted, i_out_mon.accepted);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
        end else begin
            if (psel && penable && pwrite && pready) write_shadow(paddr, pwdata);
            if (i_in_mon.valid && i_in_mon.ready)
                decode_byte(i_in_mon.rx_byte, i_in_mon.time_us);
            if (i_out_mon.valid && i_out_mon.ready) check_report();
        end
        o_fail_count     <= fail_total;
        o_pending        <= report_q.size();
        o_last_accept_us <= last_acc_us;
    end

endmodule

[tb/target_frame_decode_gate_test.sv]
// ============================================================================
// target_frame_decode_gate_test
// Byte-stream bench for the target frame decoder and gate: directed frames,
// a long output hold-off, then randomized frames, noise and broken frames
// over several register settings, checked by a side-by-side checker.
// ============================================================================
module target_frame_decode_gate_test;
    import tfdg_pkg::*;
    import tfdg_tb_pkg::*;

    localparam int STALL_LIMIT    = 5000;  // cycles without any transfer
    localparam int RX_HOLD_CYCLES = 400;   // long receiver hold-off
    localparam int SETTLE_CYCLES  = 10;    // covers the registered result path
    localparam int DRAIN_CYCLES   = 20;

    // where the tail time stamp of a frame lands
    typedef enum {TT_FREE, TT_REACQ_EDGE, TT_LOST_EDGE} tail_time_e;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    logic [31:0] last_accept_us;

    tfdg_in_if  in_ch ();
    tfdg_out_if out_ch ();

    target_frame_decode_gate u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    tfdg_gate_checker u_chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_mon         (in_ch),
        .i_out_mon        (out_ch),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_last_accept_us (last_accept_us)
    );

    // stimulus state
    logic [31:0] now_us;        // free-running microsecond clock of the stream
    int          sent_bytes;
    int          track_yaw;     // where the simulated target sits
    bit          tx_no_gaps;
    bit          rx_hold_req;
    bit          rx_holding;
    logic [31:0] cur_lost_to;
    logic [31:0] cur_reacq_to;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, a few long ones.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    // Advance the stream clock by a small random step.
    function automatic logic [31:0] next_time();
        now_us = now_us + $urandom_range(0, 80);
        return now_us;
    endfunction

    // Offer one byte, hold it until the block takes it. Entered and left at
    // a falling edge; valid stays high when the next byte follows at once.
    task automatic send_byte(input logic [7:0] b, input logic [31:0] t);
        int gap;
        gap = tx_no_gaps ? 0 : gap_len();
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid   = 1'b1;
        in_ch.rx_byte = b;
        in_ch.time_us = t;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        sent_bytes++;
    endtask

    // One frame: header, flag, yaw lo/hi, pitch lo/hi, distance, tail.
    // The tail can be stamped exactly on a timeout edge, or one past it.
    task automatic send_frame(input logic [7:0] flag, input logic signed [15:0] yaw,
                              input logic signed [15:0] pitch, input logic [7:0] dist_cm,
                              input logic [7:0] tail, input tail_time_e tt);
        logic [31:0] t;
        send_byte(HDR_BYTE, next_time());
        send_byte(flag, next_time());
        send_byte(yaw[7:0], next_time());
        send_byte(yaw[15:8], next_time());
        send_byte(pitch[7:0], next_time());
        send_byte(pitch[15:8], next_time());
        send_byte(dist_cm, next_time());
        t = next_time();
        case (tt)
            TT_REACQ_EDGE: t = last_accept_us + cur_reacq_to + $urandom_range(0, 1);
            TT_LOST_EDGE:  t = last_accept_us + cur_lost_to + $urandom_range(0, 1);
            default: ;
        endcase
        now_us = t;
        send_byte(tail, t);
    endtask

    // Frame that sits on the target: pulls the averages back to the track.
    task automatic send_clean_frame();
        send_frame(8'($urandom_range(2, 255)), 16'(track_yaw),
                   16'($urandom_range(0, 400)), 8'($urandom), TAIL_BYTE, TT_FREE);
    endtask

    // Mostly well-formed frames near the track, the rest noise, cut-off
    // frames, bad tails and frames stamped on a timeout edge.
    task automatic random_burst();
        int          r;
        int          n;
        logic [7:0]  flag;
        logic [15:0] yaw;
        logic [15:0] pitch;
        logic [7:0]  tail;
        tail_time_e  tt;

        r = $urandom_range(0, 99);
        if (r < 8) now_us = now_us + $urandom_range(100000, 800000);
        else if (r < 10) now_us = $urandom();

        r = $urandom_range(0, 99);
        if (r >= 75 && r < 85) begin
            // stray bytes; an 0xFF among them opens a frame and misaligns it
            n = $urandom_range(1, 3);
            repeat (n) send_byte(8'($urandom), next_time());
        end else if (r >= 85 && r < 92) begin
            // frame cut short; the next header lands inside it as data
            n = $urandom_range(1, 6);
            send_byte(HDR_BYTE, next_time());
            repeat (n) send_byte(8'($urandom), next_time());
        end else begin
            track_yaw = track_yaw + int'($urandom_range(0, 400)) - 200;
            if (track_yaw > 30000) track_yaw = 30000;
            if (track_yaw < -30000) track_yaw = -30000;

            n = $urandom_range(0, 99);
            if (n < 40) flag = FLAG_TRACK;
            else if (n < 75) flag = 8'($urandom_range(2, 255));
            else if (n < 90) flag = FLAG_NONE;
            else flag = 8'($urandom);

            if ($urandom_range(0, 9) == 0) yaw = 16'($urandom);
            else yaw = 16'(track_yaw + int'($urandom_range(0, 1200)) - 600);

            if ($urandom_range(0, 1) == 0) pitch = 16'($urandom);
            else pitch = 16'(int'($urandom_range(0, 4000)) - 2000);

            tail = TAIL_BYTE;
            if ($urandom_range(0, 9) == 0) begin
                tail = 8'($urandom);
                if (tail == TAIL_BYTE) tail = HDR_BYTE;
            end

            tt = TT_FREE;
            if (r >= 92) tt = ($urandom_range(0, 1) == 0) ? TT_REACQ_EDGE : TT_LOST_EDGE;

            send_frame(flag, yaw, pitch, 8'($urandom), tail, tt);
        end
    endtask

    // Hold the input idle until every result is back, then give a dropped
    // frame in flight time to clear the result path.
    task automatic wait_idle();
        in_ch.valid = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
        paddr   = {idx, 2'b00};
        pwdata  = value;
        pwrite  = 1'b1;
        psel    = 1'b1;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (idx == REG_LOST_TIMEOUT) cur_lost_to = value;
        if (idx == REG_REACQ_TIMEOUT) cur_reacq_to = value;
    endtask

    task automatic write_all(input logic [31:0] lost, input logic [31:0] reacq,
                             input logic [15:0] jump, input logic [15:0] window);
        write_reg(REG_LOST_TIMEOUT, lost);
        write_reg(REG_REACQ_TIMEOUT, reacq);
        write_reg(REG_JUMP_LIMIT, {16'd0, jump});
        write_reg(REG_TRACK_WINDOW, {16'd0, window});
    endtask

    // Random traffic for about the given number of bytes; finish on a few
    // on-track frames so the next setting starts near the target.
    task automatic run_phase(input int budget);
        int stop_at;
        stop_at = sent_bytes + budget;
        while (sent_bytes < stop_at) begin
            tx_no_gaps = ($urandom_range(0, 9) == 0);
            random_burst();
        end
        tx_no_gaps = 1'b0;
        repeat (3) send_clean_frame();
        wait_idle();
    endtask

    // Receiver: random ready with long open runs, plus one long hold-off on
    // request while the sender keeps pushing.
    initial begin
        int run;
        int gap;
        out_ch.ready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (rx_hold_req) begin
                out_ch.ready = 1'b0;
                rx_holding   = 1'b1;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
                rx_holding   = 1'b0;
                rx_hold_req  = 1'b0;
            end else begin
                out_ch.ready = 1'b1;
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 12);
                for (int k = 0; k < run && !rx_hold_req; k++) @(negedge i_clk);
                gap = gap_len();
                if (gap > 0 && !rx_hold_req) begin
                    out_ch.ready = 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.rx_byte = '0;
        in_ch.time_us = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        now_us        = '0;
        sent_bytes    = 0;
        track_yaw     = 0;
        tx_no_gaps    = 1'b0;
        rx_hold_req   = 1'b0;
        rx_holding    = 1'b0;
        cur_lost_to   = LOST_TIMEOUT_RST;
        cur_reacq_to  = REACQ_TIMEOUT_RST;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: ignored bytes outside a frame, then frames stamped just
        // below the wrap of the time counter so elapsed time wraps too.
        send_byte(8'h00, next_time());
        send_byte(8'h7E, next_time());
        now_us = 32'hFFFF_FFC0;
        // header value as the flag byte, taken as data; most negative pitch
        send_frame(HDR_BYTE, -16'sd100, 16'sh8000, 8'hFF, TAIL_BYTE, TT_FREE);
        // tracking flag, most positive pitch, zero distance
        send_frame(FLAG_TRACK, 16'sd0, 16'sh7FFF, 8'h00, TAIL_BYTE, TT_FREE);
        // bad tail: dropped without a result
        send_frame(FLAG_NONE, 16'sd0, 16'sd0, 8'h00, 8'h00, TT_FREE);
        wait_idle();

        // Hold the receiver off while frames keep coming, so the block fills
        // and stalls its input.
        rx_hold_req = 1'b1;
        wait (rx_holding);
        tx_no_gaps = 1'b1;
        repeat (12) send_clean_frame();
        tx_no_gaps = 1'b0;
        wait_idle();

        // reset values
        run_phase(300);

        // wide open: zero timeouts, widest jump limit, closed window
        write_all(32'd0, 32'd0, 16'hFFFF, 16'd0);
        run_phase(230);

        // locked: nothing passes the jump limit, timeouts never expire
        write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 16'hFFFF);
        run_phase(100);

        write_all($urandom_range(0, 900000), $urandom_range(0, 300000),
                  16'($urandom_range(1500, 9000)), 16'($urandom_range(0, 2000)));
        run_phase(280);

        write_all(LOST_TIMEOUT_RST, REACQ_TIMEOUT_RST, JUMP_LIMIT_RST, TRACK_WINDOW_RST);
        run_phase(230);

        // drain: let any stray result show up before the verdict
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[files.f]
src/tfdg_pkg.sv
src/tfdg_if.sv
src/tfdg_const_div.sv
src/tfdg_frame_parse.sv
src/target_frame_decode_gate.sv
src/tfdg_checker.sv
tb/tfdg_tb_pkg.sv
tb/tfdg_gate_checker.sv
tb/target_frame_decode_gate_test.sv
